>>> design/bpsu_pkg.sv
// ----------------------------------------------------------------------------
// bpsu_pkg
// Shared types and constants of the bitmap pixel stream unpacker.
// ----------------------------------------------------------------------------
package bpsu_pkg;

	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 13;
	localparam int CNT_W   = 12;
	localparam int PAD_W   = 2;
	localparam int INDEX_W = 2;
	localparam int CNT_CAP = 4096;

	typedef enum logic [INDEX_W-1:0] {
		REG_IMAGE_WIDTH      = 2'd0,
		REG_IMAGE_HEIGHT     = 2'd1,
		REG_TOP_DOWN         = 2'd2,
		REG_FOUR_BYTE_PIXELS = 2'd3
	} reg_index_t;

	typedef enum logic [3:0] {
		PH_BLUE  = 4'b0001,
		PH_GREEN = 4'b0010,
		PH_RED   = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] x;
		logic [CNT_W-1:0] y;
		logic             row_end;
		logic             frame_end;
		logic [CNT_W-1:0] next_col;
		logic [CNT_W-1:0] next_row;
		logic [PAD_W-1:0] pad;
	} pos_t;

endpackage

>>> design/bpsu_pixel_pos.sv
// ----------------------------------------------------------------------------
// bpsu_pixel_pos
// Clamps the image size and works out coordinates, row and frame ends, next
// counter values and row padding for the pixel being completed.
// ----------------------------------------------------------------------------
module bpsu_pixel_pos #(
	parameter int LIM_W = 4096,
	parameter int LIM_H = 4096
) (
	input  logic [bpsu_pkg::SIZE_W-1:0] image_width,
	input  logic [bpsu_pkg::SIZE_W-1:0] image_height,
	input  logic                        top_down,
	input  logic [bpsu_pkg::CNT_W-1:0]  column_count,
	input  logic [bpsu_pkg::CNT_W-1:0]  row_count,
	output bpsu_pkg::pos_t              pos
);
	import bpsu_pkg::*;

	localparam logic [SIZE_W-1:0] LW = SIZE_W'(LIM_W);
	localparam logic [SIZE_W-1:0] LH = SIZE_W'(LIM_H);

	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic [SIZE_W-1:0] h_m1;
	logic [SIZE_W-1:0] rc;
	logic [SIZE_W-1:0] col_p1;
	logic [SIZE_W-1:0] rc_p1;
	logic [3:0]        pad_full;

	always_comb begin
		if (image_width == '0) begin
			w = SIZE_W'(1);
		end else if (image_width > LW) begin
			w = LW;
		end else begin
			w = image_width;
		end
		if (image_height == '0) begin
			h = SIZE_W'(1);
		end else if (image_height > LH) begin
			h = LH;
		end else begin
			h = image_height;
		end
		h_m1   = h - SIZE_W'(1);
		rc     = ({1'b0, row_count} >= h) ? h_m1 : {1'b0, row_count};
		col_p1 = {1'b0, column_count} + SIZE_W'(1);
		rc_p1  = rc + SIZE_W'(1);
		pad_full = 4'd0 - 4'(w[1:0]) * 4'd3;

		pos.x         = column_count;
		pos.y         = top_down ? rc[CNT_W-1:0] : CNT_W'(h_m1 - rc);
		pos.row_end   = col_p1 >= w;
		pos.frame_end = pos.row_end && (rc_p1 >= h);
		pos.next_col  = pos.row_end ? '0 : col_p1[CNT_W-1:0];
		pos.next_row  = pos.frame_end ? '0 : rc_p1[CNT_W-1:0];
		pos.pad       = pad_full[PAD_W-1:0];
	end

endmodule

>>> design/bmp_pixel_stream_unpacker.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_unpacker
// Unpacks 24-bit or 32-bit bitmap pixel bytes into pixels with coordinates.
// ----------------------------------------------------------------------------
// The pixel appears on the output in the cycle after its red byte transfer.
// Throughput: one byte per cycle; input stalls only while a pixel waits unread.
// Each taken byte steps phase or padding; counters and outputs load on red bytes.
// Reset: asynchronous; counters, phase and padding clear, registers go to
// width 1, height 1, bottom-up, 24-bit.
module bmp_pixel_stream_unpacker #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpsu_pkg::INDEX_W-1:0] cfg_index,
	input  logic [bpsu_pkg::SIZE_W-1:0]  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bpsu_pkg::BYTE_W-1:0]  data_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bpsu_pkg::CNT_W-1:0]   pixel_x,
	output logic [bpsu_pkg::CNT_W-1:0]   pixel_y,
	output logic [bpsu_pkg::BYTE_W-1:0]  red,
	output logic [bpsu_pkg::BYTE_W-1:0]  green,
	output logic [bpsu_pkg::BYTE_W-1:0]  blue,
	output logic                         frame_done
);
	import bpsu_pkg::*;

	localparam int LIM_W0 = (MAX_WIDTH < CNT_CAP) ? MAX_WIDTH : CNT_CAP;
	localparam int LIM_H0 = (MAX_HEIGHT < CNT_CAP) ? MAX_HEIGHT : CNT_CAP;
	localparam int LIM_W  = (LIM_W0 < 1) ? 1 : LIM_W0;
	localparam int LIM_H  = (LIM_H0 < 1) ? 1 : LIM_H0;

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic              top_down_q;
	logic              four_q;

	phase_t            phase_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic [PAD_W-1:0]  pad_q;
	logic [BYTE_W-1:0] held_blue_q;
	logic [BYTE_W-1:0] held_green_q;

	logic              out_valid_q;
	logic [CNT_W-1:0]  pixel_x_q;
	logic [CNT_W-1:0]  pixel_y_q;
	logic [BYTE_W-1:0] red_q;
	logic [BYTE_W-1:0] green_q;
	logic [BYTE_W-1:0] blue_q;
	logic              frame_done_q;

	pos_t pos;
	logic take;
	logic emit;

	bpsu_pixel_pos #(
		.LIM_W(LIM_W),
		.LIM_H(LIM_H)
	) u_pos (
		.image_width (width_q),
		.image_height(height_q),
		.top_down    (top_down_q),
		.column_count(col_q),
		.row_count   (row_q),
		.pos         (pos)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign emit      = take && (pad_q == '0) && (phase_q == PH_RED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= SIZE_W'(1);
			height_q   <= SIZE_W'(1);
			top_down_q <= 1'b0;
			four_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:      width_q    <= cfg_data;
				REG_IMAGE_HEIGHT:     height_q   <= cfg_data;
				REG_TOP_DOWN:         top_down_q <= cfg_data[0];
				REG_FOUR_BYTE_PIXELS: four_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_BLUE;
			col_q        <= '0;
			row_q        <= '0;
			pad_q        <= '0;
			held_blue_q  <= '0;
			held_green_q <= '0;
		end else if (take) begin
			if (pad_q != '0) begin
				pad_q <= pad_q - PAD_W'(1);
			end else begin
				case (phase_q)
					PH_BLUE: begin
						held_blue_q <= data_byte;
						phase_q     <= PH_GREEN;
					end
					PH_GREEN: begin
						held_green_q <= data_byte;
						phase_q      <= PH_RED;
					end
					PH_RED: begin
						phase_q <= four_q ? PH_SKIP : PH_BLUE;
						col_q   <= pos.next_col;
						if (pos.row_end) begin
							row_q <= pos.next_row;
							if (!four_q) begin
								pad_q <= pos.pad;
							end
						end
					end
					default: phase_q <= PH_BLUE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q    <= pos.x;
			pixel_y_q    <= pos.y;
			red_q        <= data_byte;
			green_q      <= held_green_q;
			blue_q       <= held_blue_q;
			frame_done_q <= pos.frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign frame_done = frame_done_q;

endmodule

>>> design/bpsu_checker.sv
// ----------------------------------------------------------------------------
// bpsu_checker
// Port-level checks of the bitmap pixel stream unpacker, bound to the top.
// ----------------------------------------------------------------------------
module bpsu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bpsu_pkg::CNT_W-1:0]  pixel_x,
	input logic [bpsu_pkg::CNT_W-1:0]  pixel_y,
	input logic [bpsu_pkg::BYTE_W-1:0] red,
	input logic [bpsu_pkg::BYTE_W-1:0] green,
	input logic [bpsu_pkg::BYTE_W-1:0] blue,
	input logic                        frame_done
);
	import bpsu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(red) && $stable(green) && $stable(blue) && $stable(frame_done))
		else $error("pending pixel changed before transfer");

	a_out_from_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("pixel appeared without an input transfer");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while a pixel is stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind bmp_pixel_stream_unpacker bpsu_checker u_bpsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.frame_done(frame_done)
);
